>>> rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int ST_W       = 2;
  localparam int RDATA_W    = 32;
  localparam int LEN_W      = 7;
  localparam int ITEM_W     = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic check_read;
    logic idx_init;
    logic shift_rd;
    logic shift_wr;
    logic commit;
  } ple_cmd_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    logic    no_shift;
    logic    shift_last;
    logic    out_free;
  } ple_stat_t;

endpackage

>>> rtl/core/ple_req_if.sv
interface ple_req_if
  import ple_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] item_data;

  modport source (output valid, output op, output position, output item_data, input ready);
  modport sink (input valid, input op, input position, input item_data, output ready);
endinterface

>>> rtl/core/ple_rsp_if.sv
interface ple_rsp_if
  import ple_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [RDATA_W-1:0] read_data;
  logic [LEN_W-1:0]   length;
  logic               empty_res;

  modport source (output valid, output status, output read_data, output length,
                  output empty_res, input ready);
  modport sink (input valid, input status, input read_data, input length,
                input empty_res, output ready);
endinterface

>>> rtl/core/positional_list_engine_core.sv
// read, write, clear and errors pass S_IDLE, S_CHECK and S_COMMIT to the response;
// insert and remove add an S_SHIFT_RD and S_SHIFT_WR pass per moved entry
// throughput: one request in flight; the next request is taken once the
// previous result is in the output register
// reset: synchronous active-high rst empties the list and drops the pending response
module positional_list_engine_core
  import ple_pkg::*;
(
  input logic     clk,
  input logic     rst,
  ple_req_if.sink req,
  ple_rsp_if.source rsp
);

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_op        (req.op),
    .req_position  (req.position),
    .req_item_data (req.item_data),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_read_data (rsp.read_data),
    .rsp_length    (rsp.length),
    .rsp_empty_res (rsp.empty_res)
  );

endmodule

>>> rtl/core/ple_datapath.sv
module ple_datapath
  import ple_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ple_cmd_t           cmd,
  output ple_stat_t          stat,
  input  logic [OP_W-1:0]    req_op,
  input  logic [POS_W-1:0]   req_position,
  input  logic [ITEM_W-1:0]  req_item_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [ST_W-1:0]    rsp_status,
  output logic [RDATA_W-1:0] rsp_read_data,
  output logic [LEN_W-1:0]   rsp_length,
  output logic               rsp_empty_res
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  op_t                   op;
  logic [POS_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] data;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [ADDR_W-1:0]     idx;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  ins_ok;
  logic                  pos_ok;
  logic                  full;
  status_t               status_c;
  logic [ADDR_W-1:0]     pos_idx;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  always_comb begin
    pos_idx = ADDR_W'(pos - POS_W'(1));
    ins_ok  = (pos != '0) && ({1'b0, pos} <= (POS_W + 1)'(count) + (POS_W + 1)'(1));
    pos_ok  = (pos != '0) && ({1'b0, pos} <= (POS_W + 1)'(count));
    full    = (count == CNT_W'(CAPACITY));
    unique case (op)
      OP_INSERT: status_c = !ins_ok ? ST_BADPOS : (full ? ST_FULL : ST_OK);
      OP_REMOVE, OP_READ, OP_WRITE: status_c = pos_ok ? ST_OK : ST_BADPOS;
      OP_CLEAR: status_c = ST_OK;
      default: status_c = ST_BADPOS;
    endcase
  end

  always_comb begin
    stat.op       = op;
    stat.status   = status_c;
    stat.out_free = !rsp_valid || rsp_ready;
    if (op == OP_INSERT) begin
      stat.no_shift   = ((POS_W + 1)'(count) + (POS_W + 1)'(1)) == {1'b0, pos};
      stat.shift_last = (POS_W + 1)'(idx) == {1'b0, pos};
    end else begin
      stat.no_shift   = {1'b0, pos} >= (POS_W + 1)'(count);
      stat.shift_last = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(2)) >= (CNT_W + 1)'(count);
    end
  end

  always_comb begin
    unique case (op)
      OP_INSERT: count_next = count + CNT_W'(1);
      OP_REMOVE: count_next = count - CNT_W'(1);
      OP_CLEAR:  count_next = '0;
      default:   count_next = count;
    endcase
    if (status_c != ST_OK) begin
      count_next = count;
    end
  end

  // shift reads the neighbor that moves into idx
  always_comb begin
    if (cmd.shift_rd) begin
      rd_addr = (op == OP_INSERT) ? idx - ADDR_W'(1) : idx + ADDR_W'(1);
    end else begin
      rd_addr = pos_idx;
    end
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rdata;
    if (cmd.shift_wr) begin
      wr_en = 1'b1;
    end else if (cmd.commit && status_c == ST_OK && (op == OP_INSERT || op == OP_WRITE)) begin
      wr_en   = 1'b1;
      wr_addr = pos_idx;
      wr_data = data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.check_read || cmd.shift_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= op_t'(req_op);
      pos  <= req_position;
      data <= req_item_data[DATA_WIDTH-1:0];
    end
    if (cmd.idx_init) begin
      idx <= (op == OP_INSERT) ? count[ADDR_W-1:0] : pos_idx;
    end else if (cmd.shift_wr) begin
      idx <= (op == OP_INSERT) ? idx - ADDR_W'(1) : idx + ADDR_W'(1);
    end
    if (cmd.commit) begin
      rsp_status    <= status_c;
      rsp_read_data <= (op == OP_READ && status_c == ST_OK) ? RDATA_W'(rdata) : '0;
      rsp_length    <= LEN_W'(count_next);
      rsp_empty_res <= (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/ple_ctrl.sv
module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ple_stat_t stat,
  output ple_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = !rst;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_COMMIT;
        if (stat.status == ST_OK) begin
          if (stat.op == OP_READ) begin
            cmd.check_read = 1'b1;
          end else if (stat.op == OP_INSERT || stat.op == OP_REMOVE) begin
            cmd.idx_init = 1'b1;
            if (!stat.no_shift) begin
              state_next = S_SHIFT_RD;
            end
          end
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = stat.shift_last ? S_COMMIT : S_SHIFT_RD;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
